/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HDPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hdpc assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define HDPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hdpc assertion failed");

// Next-cycle implication, also checked through reset
`define HDPC_ASSERT_NXT_ALL(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("hdpc assertion failed");

`endif

/* rtl/hdpc_pkg.sv */
// ----------------------------------------------------------------------------
// hdpc_pkg
// Types and constants of the debounced hysteresis pulse counter.
// ----------------------------------------------------------------------------
package hdpc_pkg;

    // Field widths fixed by the register map and the item format
    localparam int THR_W      = 10;
    localparam int DELAY_W    = 20;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Default sample width
    localparam int SAMPLE_BITS_DEF = 10;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Register indexes
    localparam t_cfg_idx CFG_RISING_THR  = 2'd0;
    localparam t_cfg_idx CFG_FALLING_THR = 2'd1;
    localparam t_cfg_idx CFG_DEBOUNCE    = 2'd2;

    // Register reset values
    localparam logic [THR_W-1:0]   RISING_THR_RST  = 10'd600;
    localparam logic [THR_W-1:0]   FALLING_THR_RST = 10'd400;
    localparam logic [DELAY_W-1:0] DEBOUNCE_RST    = 20'd2000;

    // Opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

endpackage

/* rtl/hysteresis_debounce_pulse_counter.sv */
// ----------------------------------------------------------------------------
// hysteresis_debounce_pulse_counter
// Schmitt-trigger comparator with time-based debounce and a pulse counter.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the output is stalled, and returns
// exactly one result per item: an input register holds the item, one pass
// of compare, 32-bit subtract and increment logic updates level, agree
// time and count, and a result register presents it.
// A sample item proposes high above the rising threshold (from low) or low
// below the falling threshold (from high); a change is taken only when the
// wrapping time since the last agreeing sample exceeds the debounce delay.
// A clear item reports the count and zeroes it. Registers are to be written
// only while the block is idle; the block itself does not enforce this.
module hysteresis_debounce_pulse_counter #(
    parameter int SAMPLE_BITS = hdpc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  hdpc_pkg::t_cfg_idx              i_cfg_index,
    input  logic [hdpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_opcode,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    input  logic [hdpc_pkg::TIME_W-1:0]     i_time_us,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [hdpc_pkg::COUNT_W-1:0]    o_pulse_count,
    output logic                            o_stable_level,
    output logic                            o_pulse_seen
);
    import hdpc_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

    // configuration registers
    logic [THR_W-1:0]   r_rising_thr;
    logic [THR_W-1:0]   r_falling_thr;
    logic [DELAY_W-1:0] r_debounce;

    // input register
    logic                   r_in_valid;
    logic                   r_opcode;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [TIME_W-1:0]      r_time_us;

    // block state
    logic               r_level;
    logic [TIME_W-1:0]  r_agree_time;
    logic [COUNT_W-1:0] r_count;

    // result register
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_pulse_count;
    logic               r_stable_level;
    logic               r_pulse_seen;

    // next values
    logic               n_level;
    logic [TIME_W-1:0]  n_agree_time;
    logic [COUNT_W-1:0] n_count;
    logic [COUNT_W-1:0] n_pulse_count;
    logic               n_pulse_seen;

    logic              out_ready;
    logic              in_load;
    logic              fire;
    logic              proposed;
    logic [CMP_W-1:0]  sample_x;
    logic [TIME_W-1:0] elapsed;

    // handshake: the result register frees when empty or being taken
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_ready;
    assign in_load    = !r_in_valid || out_ready;
    assign o_in_stall = !in_load;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rising_thr  <= RISING_THR_RST;
            r_falling_thr <= FALLING_THR_RST;
            r_debounce    <= DEBOUNCE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RISING_THR:  r_rising_thr  <= i_cfg_data[THR_W-1:0];
                CFG_FALLING_THR: r_falling_thr <= i_cfg_data[THR_W-1:0];
                CFG_DEBOUNCE:    r_debounce    <= i_cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_opcode  <= i_opcode;
            r_sample  <= i_sample;
            r_time_us <= i_time_us;
        end
    end

    // comparator, debounce and count update
    assign sample_x = CMP_W'(r_sample);
    assign elapsed  = r_time_us - r_agree_time;

    always_comb begin
        n_level       = r_level;
        n_agree_time  = r_agree_time;
        n_count       = r_count;
        n_pulse_count = r_count;
        n_pulse_seen  = 1'b0;
        proposed      = r_level;
        if (r_opcode == OP_CLEAR) begin
            n_count = '0;
        end else begin
            if (r_level) begin
                proposed = !(sample_x < CMP_W'(r_falling_thr));
            end else begin
                proposed = sample_x > CMP_W'(r_rising_thr);
            end
            if (proposed != r_level) begin
                if (elapsed > TIME_W'(r_debounce)) begin
                    n_level = proposed;
                    if (proposed) begin
                        n_count      = r_count + COUNT_W'(1);
                        n_pulse_seen = 1'b1;
                    end
                end
            end else begin
                n_agree_time = r_time_us;
            end
            n_pulse_count = n_count;
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level      <= 1'b0;
            r_agree_time <= '0;
            r_count      <= '0;
        end else if (fire) begin
            r_level      <= n_level;
            r_agree_time <= n_agree_time;
            r_count      <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_pulse_count  <= n_pulse_count;
            r_stable_level <= n_level;
            r_pulse_seen   <= n_pulse_seen;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pulse_count  = r_pulse_count;
    assign o_stable_level = r_stable_level;
    assign o_pulse_seen   = r_pulse_seen;

endmodule

/* rtl/hdpc_checker.sv */
// ----------------------------------------------------------------------------
// hdpc_checker
// Port-level checks for the debounced hysteresis pulse counter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hdpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_pulse_count,
    input logic        o_stable_level,
    input logic        o_pulse_seen
);

    // reset empties the result register
    `HDPC_ASSERT_NXT_ALL(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)

    // input backs up only behind a full, stalled result
    `HDPC_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // an accepted rising change leaves the level high
    `HDPC_ASSERT_IMP(a_pulse_high, i_clk, i_rst_n, o_out_valid && o_pulse_seen, o_stable_level)

    // a stalled result holds its count
    `HDPC_ASSERT_NXT(a_hold_count, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_pulse_count))

endmodule

bind hysteresis_debounce_pulse_counter hdpc_checker u_hdpc_checker (.*);

/* sim/hysteresis_debounce_pulse_counter_tb.sv */
// ----------------------------------------------------------------------------
// hysteresis_debounce_pulse_counter_tb
// Self-checking bench for the debounced hysteresis pulse counter. A short
// table of samples and clears covers threshold edges, the debounce boundary,
// timestamp wrap and the clear path. Random phases follow under several
// threshold and debounce settings. Both channels idle and stall at random,
// and one long output hold-off backs the pipe up. Every result transfer is
// checked against a typed row or behavioral predictor of level, agree time, count.
// ----------------------------------------------------------------------------
module hysteresis_debounce_pulse_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hdpc_pkg::*;

    localparam int SAMPLE_W       = SAMPLE_BITS_DEF;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 6;
    localparam int REPORT_MAX     = 10;
    localparam int PHASE_ITEMS    = 250;
    localparam int PROBE_ROWS     = 18;
    // index past the register map, must be ignored
    localparam t_cfg_idx CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               level;
        logic               seen;
    } t_pulse_result;

    typedef struct {
        logic                op;
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   stamp;
        bit                  typed;
        t_pulse_result       result;
    } t_probe_row;

    // Directed rows, all under the reset register values (600 / 400 / 2000)
    t_probe_row probe_table [PROBE_ROWS] = '{
        // clear straight after reset
        '{OP_CLEAR,  10'd1023, 32'hFFFF_FFFF, 1'b1, '{32'd0, 1'b0, 1'b0}},
        '{OP_SAMPLE, 10'd0,    32'd0,         1'b1, '{32'd0, 1'b0, 1'b0}},
        // elapsed equal to the delay: not yet accepted
        '{OP_SAMPLE, 10'd601,  32'd2000,      1'b0, '0},
        '{OP_SAMPLE, 10'd1023, 32'd2001,      1'b1, '{32'd1, 1'b1, 1'b1}},
        // reading equal to the falling threshold still agrees with high
        '{OP_SAMPLE, 10'd400,  32'd2500,      1'b0, '0},
        '{OP_SAMPLE, 10'd0,    32'd4500,      1'b0, '0},
        '{OP_SAMPLE, 10'd399,  32'd4501,      1'b0, '0},
        // agree time kept across the accepted fall, so the rise is immediate
        '{OP_SAMPLE, 10'd601,  32'd4502,      1'b0, '0},
        '{OP_SAMPLE, 10'd600,  32'd4503,      1'b0, '0},
        '{OP_CLEAR,  10'd0,    32'd0,         1'b1, '{32'd2, 1'b1, 1'b0}},
        // timestamp wrap on the way down and on the way up
        '{OP_SAMPLE, 10'd1023, 32'hFFFF_FFF0, 1'b0, '0},
        '{OP_SAMPLE, 10'd0,    32'd2000,      1'b0, '0},
        '{OP_SAMPLE, 10'd0,    32'hFFFF_FFFF, 1'b0, '0},
        '{OP_SAMPLE, 10'd1023, 32'd2000,      1'b0, '0},
        '{OP_SAMPLE, 10'd682,  32'hAAAA_AAAA, 1'b0, '0},
        '{OP_SAMPLE, 10'd341,  32'h5555_5555, 1'b0, '0},
        '{OP_SAMPLE, 10'd0,    32'h8000_0000, 1'b0, '0},
        '{OP_CLEAR,  10'd682,  32'h5555_5555, 1'b0, '0}
    };

    // DUT signals
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    t_cfg_idx              i_cfg_index    = CFG_RISING_THR;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic                  i_opcode       = OP_SAMPLE;
    logic [SAMPLE_W-1:0]   i_sample       = '0;
    logic [TIME_W-1:0]     i_time_us      = '0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic [COUNT_W-1:0]    o_pulse_count;
    logic                  o_stable_level;
    logic                  o_pulse_seen;

    // Predictor copy of registers and state
    logic [THR_W-1:0]   model_rise  = RISING_THR_RST;
    logic [THR_W-1:0]   model_fall  = FALLING_THR_RST;
    logic [DELAY_W-1:0] model_delay = DEBOUNCE_RST;
    logic               model_level = 1'b0;
    logic [TIME_W-1:0]  model_agree = '0;
    logic [COUNT_W-1:0] model_count = '0;

    t_pulse_result expected_results [$];

    int error_count = 0;
    int cycle_count = 0;
    bit send_gaps   = 1'b1;
    bit recv_gaps   = 1'b1;
    bit hold_armed  = 1'b0;
    int hold_count  = 0;

    hysteresis_debounce_pulse_counter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_sample       (i_sample),
        .i_time_us      (i_time_us),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pulse_count  (o_pulse_count),
        .o_stable_level (o_stable_level),
        .o_pulse_seen   (o_pulse_seen)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Schmitt compare, debounce and count for one item; updates the copy state
    function automatic t_pulse_result step_debounce(logic op, logic [SAMPLE_W-1:0] sample,
                                                    logic [TIME_W-1:0] stamp);
        t_pulse_result      r;
        logic               proposal;
        logic [TIME_W-1:0]  elapsed;
        r.seen = 1'b0;
        if (op == OP_CLEAR) begin
            r.count     = model_count;
            r.level     = model_level;
            model_count = '0;
            return r;
        end
        proposal = model_level ? (sample >= model_fall) : (sample > model_rise);
        if (proposal != model_level) begin
            elapsed = stamp - model_agree;
            if (elapsed > {{(TIME_W-DELAY_W){1'b0}}, model_delay}) begin
                model_level = proposal;
                if (proposal) begin
                    model_count = model_count + 1'b1;
                    r.seen      = 1'b1;
                end
            end
        end else begin
            model_agree = stamp;
        end
        r.count = model_count;
        r.level = model_level;
        return r;
    endfunction

    // Reading from the rising threshold up, or from zero up to the falling one
    function automatic logic [SAMPLE_W-1:0] pick_reading(bit high);
        if (high)
            return SAMPLE_W'($urandom_range(model_rise, SAMPLE_MAX));
        return SAMPLE_W'($urandom_range(0, model_fall));
    endfunction

    // One input transfer; queues the typed or predicted result on acceptance
    task automatic send_item(logic op, logic [SAMPLE_W-1:0] sample,
                             logic [TIME_W-1:0] stamp, bit typed,
                             t_pulse_result typed_result);
        t_pulse_result predicted;
        while (send_gaps && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_sample   <= sample;
        i_time_us  <= stamp;
        do @(posedge i_clk); while (o_in_stall);
        predicted = step_debounce(op, sample, stamp);
        expected_results.push_back(typed ? typed_result : predicted);
    endtask

    // Wait for every outstanding result, then let the pipe go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write per cycle; write enable stays up across a burst
    task automatic program_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_RISING_THR:  model_rise  = data[THR_W-1:0];
            CFG_FALLING_THR: model_fall  = data[THR_W-1:0];
            CFG_DEBOUNCE:    model_delay = data[DELAY_W-1:0];
            default: ;
        endcase
    endtask

    // Thresholds carry random upper bits, which the block must drop
    task automatic apply_setting(logic [THR_W-1:0] rise, logic [THR_W-1:0] fall,
                                 logic [DELAY_W-1:0] dly);
        program_reg(CFG_RISING_THR, CFG_DATA_W'({$urandom, rise}));
        program_reg(CFG_FALLING_THR, CFG_DATA_W'({$urandom, fall}));
        program_reg(CFG_DEBOUNCE, dly);
        program_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // Square-wave-like light signal with noise, time jumps and clears
    task automatic run_phase(int items);
        logic [TIME_W-1:0]   stamp;
        logic [SAMPLE_W-1:0] sample;
        t_pulse_result       unused;
        bit                  high;
        int                  roll;
        stamp  = $urandom;
        high   = model_level;
        unused = '0;
        for (int n = 0; n < items; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                send_item(OP_CLEAR, SAMPLE_W'($urandom), $urandom, 1'b0, unused);
            end else begin
                if ($urandom_range(0, 99) < 8)
                    high = !high;
                if (roll < 10)
                    stamp = $urandom;
                else
                    stamp = stamp + $urandom_range(0, 2 * model_delay + 4);
                sample = (roll < 18) ? SAMPLE_W'($urandom) : pick_reading(high);
                send_item(OP_SAMPLE, sample, stamp, 1'b0, unused);
            end
        end
    endtask

    task automatic flag_error(string what, t_pulse_result want, t_pulse_result got);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("%0t %s: expected count=%0d level=%0b seen=%0b, %s",
                     $time, what, want.count, want.level, want.seen,
                     $sformatf("got count=%0d level=%0b seen=%0b",
                               got.count, got.level, got.seen));
    endtask

    // Output side: random stall, plus one long hold-off once armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_armed && hold_count < HOLD_CYCLES) begin
            i_out_stall <= 1'b1;
            hold_count  <= hold_count + 1;
        end else begin
            i_out_stall <= recv_gaps && ($urandom_range(0, 99) < 15);
        end
    end

    // Result checker: one comparison per output transfer
    always @(posedge i_clk) begin
        t_pulse_result want;
        t_pulse_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_pulse_count, o_stable_level, o_pulse_seen};
            if (expected_results.size() == 0) begin
                flag_error("unexpected result", '0, got);
            end else begin
                want = expected_results.pop_front();
                if (got.count !== want.count || got.level !== want.level ||
                    got.seen !== want.seen)
                    flag_error("mismatch", want, got);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= TIMEOUT_CYCLES);
        $display("FAILURE");
        $finish;
    end

    // Main sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table under reset values
        for (int n = 0; n < PROBE_ROWS; n++)
            send_item(probe_table[n].op, probe_table[n].sample, probe_table[n].stamp,
                      probe_table[n].typed, probe_table[n].result);
        settle();

        // reset values written back explicitly
        apply_setting(RISING_THR_RST, FALLING_THR_RST, DEBOUNCE_RST);
        run_phase(PHASE_ITEMS);
        settle();

        // widest hysteresis: no reading can ever change the level
        apply_setting(10'd1023, 10'd0, 20'd0);
        run_phase(PHASE_ITEMS);
        settle();

        // crossed extremes, zero delay, no idling on either side
        send_gaps = 1'b0;
        recv_gaps <= 1'b0;
        apply_setting(10'd0, 10'd1023, 20'd0);
        run_phase(PHASE_ITEMS);
        settle();

        // longest debounce; long output hold-off while input keeps offering
        recv_gaps  <= 1'b1;
        hold_armed <= 1'b1;
        apply_setting(10'd512, 10'd511, 20'hF_FFFF);
        run_phase(PHASE_ITEMS);
        settle();

        // crossed thresholds, short delay
        send_gaps = 1'b1;
        apply_setting(10'd100, 10'd900, 20'd50);
        run_phase(PHASE_ITEMS);
        settle();

        // random settings
        repeat (2) begin
            apply_setting(THR_W'($urandom), THR_W'($urandom),
                          DELAY_W'($urandom_range(0, 5000)));
            run_phase(PHASE_ITEMS);
            settle();
        end

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
